[src/combined_lcg_shuffle_rng_defines.svh]
// Assertion macros used by the combined_lcg_shuffle_rng checker.
// Needs nothing else; included by the checker file.
`ifndef COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH

// Check cons in the same cycle as ante.
`define CLSR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define CLSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/clsr_pkg.sv]
// Shared types and constants of the combined LCG shuffle generator.
// No dependencies; imported by every RTL module of the block but clsr_ram.
package clsr_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 32;

    localparam int VAL_W       = 31;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int LCG_HI_W    = 16;
    localparam int FOLD_C_W    = 8;
    localparam int SC_W        = 39;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 64;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Moduli are 2^31 - C, so a product folds as lo + hi * C.
    localparam logic [31:0]         M1        = 32'd2147483563;
    localparam logic [31:0]         M2        = 32'd2147483399;
    localparam logic [31:0]         MM1       = 32'd2147483562;
    localparam logic [FOLD_C_W-1:0] FOLD_C1   = 8'd85;
    localparam logic [FOLD_C_W-1:0] FOLD_C2   = 8'd249;
    localparam logic [VAL_W-1:0]    LCG_A1    = 31'd40014;
    localparam logic [VAL_W-1:0]    LCG_A2    = 31'd40692;
    localparam logic [VAL_W-1:0]    SCALE_CAP = 31'd2147483305;

    localparam logic CMD_RESEED = 1'b0;
    localparam logic CMD_DRAW   = 1'b1;

    // word index of the seed register
    localparam logic [APB_ADDR_W-3:0] REG_SEED = '0;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_FIRST,
        MUL_SECOND,
        MUL_SCALE
    } t_mul_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WARM_MUL,
        S_WARM_FOLD,
        S_D_SECOND,
        S_D_READ,
        S_D_UPDATE,
        S_D_SCALE,
        S_D_FOLD1,
        S_D_FOLD2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    in_load;
        logic    seed_load;
        t_mul_op mul_op;
        logic    warm_wr;
        logic    ram_rd;
        logic    upd;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
    } t_dp_status;

endpackage

[src/combined_lcg_shuffle_rng.sv]
// Each reseed warm-up step goes through the shared multiplier in S_WARM_MUL, then S_WARM_FOLD.
// Throughput: one item at a time; the input reopens as the result loads, and a result
// stalled in the output register holds the next one in its last state.
// Reset (synchronous, active low) clears control state and the seed; the table is
// undefined until a reseed fills it. Depends on clsr_pkg, clsr_ctrl, clsr_datapath.
module combined_lcg_shuffle_rng #(
    parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [clsr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // range_limit
    input  logic [clsr_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // cmd
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [clsr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // raw_value, scaled_value
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [clsr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [clsr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [clsr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import clsr_pkg::*;

    logic [VAL_W-1:0] r_seed;
    logic             w_seed_sel;
    logic             w_cfg_wr;
    t_dp_cmd          w_cmd;
    t_dp_status       w_status;
    logic [VAL_W-1:0] w_raw, w_scaled;

    assign pready     = 1'b1;
    assign w_seed_sel = (paddr[APB_ADDR_W-1:2] == REG_SEED);
    assign w_cfg_wr   = psel && penable && pwrite && pready && w_seed_sel;
    assign prdata     = w_seed_sel ? APB_DATA_W'(r_seed) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (w_cfg_wr) begin
            r_seed <= pwdata[VAL_W-1:0];
        end
    end

    clsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_kind   (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    clsr_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_seed   (r_seed),
        .i_limit  (s_axis_tdata[VAL_W-1:0]),
        .o_raw    (w_raw),
        .o_scaled (w_scaled)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - 2 * VAL_W)'(0), w_scaled, w_raw};

endmodule

[src/clsr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clsr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/clsr_datapath.sv]
// Datapath: both generators, shared multiplier with modular folds, table index compare,
// shuffle table and output word register. Depends on clsr_pkg and clsr_ram.
module clsr_datapath #(
    parameter int TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  clsr_pkg::t_dp_cmd              i_cmd,
    output clsr_pkg::t_dp_status           o_status,
    input  logic [clsr_pkg::VAL_W-1:0]     i_seed,
    input  logic [clsr_pkg::VAL_W-1:0]     i_limit,
    output logic [clsr_pkg::VAL_W-1:0]     o_raw,
    output logic [clsr_pkg::VAL_W-1:0]     o_scaled
);
    import clsr_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 8);
    localparam int HIC_W  = LCG_HI_W + FOLD_C_W;
    localparam logic [31:0]      NDIV      = 32'd1 + MM1 / 32'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(TABLE_DEPTH + 7);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(TABLE_DEPTH);

    logic [VAL_W-1:0]  r_first, r_second, r_shuffle, r_limit;
    logic [PROD_W-1:0] r_prod;
    t_mul_op           r_prod_op;
    logic [VAL_W-1:0]  r_sc_hi;
    logic [SC_W-1:0]   r_sc_r1;
    logic              r_sc_stage2;
    logic [VAL_W-1:0]  r_scaled;
    logic [CNT_W-1:0]  r_cnt;
    logic [VAL_W-1:0]  r_out_raw, r_out_scaled;

    logic [VAL_W-1:0]    w_start;
    logic [VAL_W-1:0]    w_mul_a, w_mul_b, w_capped;
    logic [PROD_W-1:0]   w_prod;
    logic [FOLD_C_W-1:0] w_fold_c;
    logic [31:0]         w_fold_m;
    logic [HIC_W-1:0]    w_lcg_hic;
    logic [31:0]         w_lcg_sum;
    logic [VAL_W-1:0]    w_fold;
    logic [SC_W-1:0]     w_sc_r1;
    logic [SC_W-VAL_W-1:0] w_h1;
    logic [31:0]         w_r2;
    logic                w_r2_ge;
    logic [31:0]         w_q;
    logic [TABLE_DEPTH-1:0] w_idx_therm;
    logic [TABLE_DEPTH-1:0] w_idx_hot;
    logic [IDX_W-1:0]    w_idx;
    logic [VAL_W-1:0]    w_ram_rdata;
    logic [31:0]         w_diff;
    logic [VAL_W-1:0]    w_shuf_new;
    logic                w_shuf_we;
    logic [VAL_W-1:0]    w_shuf_val;
    logic                w_warm_in_table;
    logic                w_ram_we;
    logic [IDX_W-1:0]    w_ram_waddr;
    logic [VAL_W-1:0]    w_ram_wdata;

    // seed + 1, with the all-ones seed wrapping to a start of 1
    assign w_start  = (&i_seed) ? VAL_W'(1) : i_seed + VAL_W'(1);
    assign w_capped = (r_shuffle > SCALE_CAP) ? SCALE_CAP : r_shuffle;

    always_comb begin
        case (i_cmd.mul_op)
            MUL_FIRST: begin
                w_mul_a = r_first;
                w_mul_b = LCG_A1;
            end
            MUL_SECOND: begin
                w_mul_a = r_second;
                w_mul_b = LCG_A2;
            end
            MUL_SCALE: begin
                w_mul_a = w_capped;
                w_mul_b = r_limit;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // a * x mod m: x < 2^31, a < 2^16, so one fold and one subtract suffice
    assign w_fold_c  = (r_prod_op == MUL_SECOND) ? FOLD_C2 : FOLD_C1;
    assign w_fold_m  = (r_prod_op == MUL_SECOND) ? M2 : M1;
    assign w_lcg_hic = HIC_W'(r_prod[VAL_W +: LCG_HI_W]) * HIC_W'(w_fold_c);
    assign w_lcg_sum = 32'(r_prod[VAL_W-1:0]) + 32'(w_lcg_hic);
    assign w_fold    = (w_lcg_sum >= w_fold_m) ? VAL_W'(w_lcg_sum - w_fold_m)
                                               : w_lcg_sum[VAL_W-1:0];

    // floor(P / M1) in two folds: quotient hi + h1, plus one if r2 >= M1
    assign w_sc_r1 = SC_W'(r_prod[PROD_W-1:VAL_W]) * SC_W'(FOLD_C1)
                   + SC_W'(r_prod[VAL_W-1:0]);
    assign w_h1    = r_sc_r1[SC_W-1:VAL_W];
    assign w_r2    = 32'(r_sc_r1[VAL_W-1:0]) + 32'(w_h1) * 32'(FOLD_C1);
    assign w_r2_ge = (w_r2 >= M1);
    assign w_q     = 32'(r_sc_hi) + 32'(w_h1) + 32'(w_r2_ge);

    // table index: compare the shuffle output against every bucket bound at once,
    // then encode the top bound reached; the last bucket also takes any overflow
    always_comb begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            w_idx_therm[k] = (32'(r_shuffle) >= NDIV * 32'(k));
        end
    end

    assign w_idx_hot = w_idx_therm & ~(w_idx_therm >> 1);

    always_comb begin
        w_idx = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            w_idx = w_idx | ({IDX_W{w_idx_hot[k]}} & IDX_W'(k));
        end
    end

    assign w_diff     = 32'(w_ram_rdata) - 32'(r_second);
    assign w_shuf_new = w_diff[31] ? VAL_W'(w_diff + MM1) : w_diff[VAL_W-1:0];

    assign w_warm_in_table = i_cmd.warm_wr && (r_cnt < CNT_DEPTH);
    assign w_shuf_we       = i_cmd.upd || (i_cmd.warm_wr && (r_cnt == '0));
    assign w_shuf_val      = i_cmd.upd ? w_shuf_new : w_fold;

    assign w_ram_we    = w_warm_in_table || i_cmd.upd;
    assign w_ram_waddr = i_cmd.upd ? w_idx : r_cnt[IDX_W-1:0];
    assign w_ram_wdata = i_cmd.upd ? r_first : w_fold;

    clsr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (w_idx),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_op   <= MUL_NONE;
            r_sc_stage2 <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_prod_op   <= i_cmd.mul_op;
            r_sc_stage2 <= (r_prod_op == MUL_SCALE);
            if (i_cmd.seed_load) begin
                r_cnt <= CNT_START;
            end else if (i_cmd.warm_wr) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_cmd.in_load) begin
            r_limit <= i_limit;
        end
        if (i_cmd.seed_load) begin
            r_first  <= w_start;
            r_second <= w_start;
            r_scaled <= '0;
        end else begin
            if (r_prod_op == MUL_FIRST) begin
                r_first <= w_fold;
            end
            if (r_prod_op == MUL_SECOND) begin
                r_second <= w_fold;
            end
            if (r_sc_stage2) begin
                r_scaled <= w_q[VAL_W-1:0];
            end
        end
        if (r_prod_op == MUL_SCALE) begin
            r_sc_hi <= r_prod[PROD_W-1:VAL_W];
            r_sc_r1 <= w_sc_r1;
        end
        if (w_shuf_we) begin
            r_shuffle <= w_shuf_val;
        end
        if (i_cmd.out_load) begin
            r_out_raw    <= r_shuffle;
            r_out_scaled <= r_scaled;
        end
    end

    assign o_status.cnt_zero = (r_cnt == '0);
    assign o_raw             = r_out_raw;
    assign o_scaled          = r_out_scaled;

endmodule

[src/clsr_ctrl.sv]
// Controller: sequences reseed warm-up and draw steps, owns the handshakes.
// Depends on clsr_pkg.
module clsr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_kind,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output clsr_pkg::t_dp_cmd    o_cmd,
    input  clsr_pkg::t_dp_status i_status
);
    import clsr_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_kind == CMD_DRAW) ? S_D_SECOND : S_WARM_MUL;
                end
            end
            S_WARM_MUL:  n_state = S_WARM_FOLD;
            S_WARM_FOLD: n_state = i_status.cnt_zero ? S_DONE : S_WARM_MUL;
            S_D_SECOND:  n_state = S_D_READ;
            S_D_READ:    n_state = S_D_UPDATE;
            S_D_UPDATE:  n_state = S_D_SCALE;
            S_D_SCALE:   n_state = S_D_FOLD1;
            S_D_FOLD1:   n_state = S_D_FOLD2;
            S_D_FOLD2:   n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.mul_op = MUL_NONE;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.in_load = 1'b1;
                    if (i_in_kind == CMD_DRAW) begin
                        o_cmd.mul_op = MUL_FIRST;
                    end else begin
                        o_cmd.seed_load = 1'b1;
                    end
                end
            end
            S_WARM_MUL:  o_cmd.mul_op = MUL_FIRST;
            S_WARM_FOLD: o_cmd.warm_wr = 1'b1;
            S_D_SECOND:  o_cmd.mul_op = MUL_SECOND;
            S_D_READ:    o_cmd.ram_rd = 1'b1;
            S_D_UPDATE:  o_cmd.upd = 1'b1;
            S_D_SCALE:   o_cmd.mul_op = MUL_SCALE;
            S_DONE:      o_cmd.out_load = w_out_free;
            default: ;
        endcase
    end

    assign n_out_valid = o_cmd.out_load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[src/clsr_checker.sv]
// Port-level checks of combined_lcg_shuffle_rng, attached by bind.
// Depends on clsr_pkg and combined_lcg_shuffle_rng_defines.svh.
`include "combined_lcg_shuffle_rng_defines.svh"

module clsr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [clsr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [clsr_pkg::APB_ADDR_W-1:0]     paddr,
    input logic [clsr_pkg::APB_DATA_W-1:0]     pwdata,
    input logic [clsr_pkg::APB_DATA_W-1:0]     prdata,
    input logic                                pready
);
    import clsr_pkg::*;

    // a stalled result word holds
    `CLSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

    // one word at a time: the input side closes right after an accept
    `CLSR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while an item is in flight")

    // a fresh result comes only out of a busy period
    `CLSR_ASSERT_SAME(a_result_from_work, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(!s_axis_tready), "result appeared without work in flight")

    // seed read-back matches the last write
    `CLSR_ASSERT_SAME(a_seed_readback, i_clk, i_rst_n, (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_SEED) ##1 (psel && !pwrite && paddr[APB_ADDR_W-1:2] == REG_SEED), (prdata[VAL_W-1:0] == $past(pwdata[VAL_W-1:0])) && !prdata[APB_DATA_W-1], "seed read-back mismatch")

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (.*);

[verif/combined_lcg_shuffle_rng_test.sv]
// Self-checking bench for combined_lcg_shuffle_rng: predicts each result word with an
// in-bench copy of the two-generator shuffle scheme and compares every word it receives.
// Depends on clsr_pkg and the combined_lcg_shuffle_rng RTL.
`timescale 1ns / 100ps

module combined_lcg_shuffle_rng_test;
    import clsr_pkg::*;

    localparam int       TBL_DEPTH = TABLE_DEPTH_DEFAULT;
    localparam longint   GEN1_M    = M1;
    localparam longint   GEN1_A    = LCG_A1;
    localparam longint   GEN1_Q    = 53668;
    localparam longint   GEN1_R    = 12211;
    localparam longint   GEN2_M    = M2;
    localparam longint   GEN2_A    = LCG_A2;
    localparam longint   GEN2_Q    = 52774;
    localparam longint   GEN2_R    = 3791;
    localparam longint   WRAP_ADD  = MM1;
    localparam longint   BUCKET    = 1 + WRAP_ADD / TBL_DEPTH;
    localparam longint   VAL_MAX   = 64'h7FFF_FFFF;
    // seeds whose start lands exactly on a modulus
    localparam logic [30:0] SEED_ZERO_GEN1 = 31'd2147483562;
    localparam logic [30:0] SEED_ZERO_GEN2 = 31'd2147483398;

    typedef struct packed {
        logic [30:0] raw;
        logic [30:0] scaled;
    } t_rng_word;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;   // range_limit
    logic [IN_TUSER_W-1:0]   s_axis_tuser;   // cmd
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // raw_value, scaled_value
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // predictor state
    logic [30:0] seed_reg;
    longint      gen1_state;
    longint      gen2_state;
    longint      shuffle_reg;
    longint      shuffle_tbl [TBL_DEPTH];

    t_rng_word   rng_words_due [$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    combined_lcg_shuffle_rng i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint schrage_step(longint x, longint a, longint m, longint q,
                                            longint r);
        longint k;
        longint y;
        k = x / q;
        y = a * (x - k * q) - k * r;
        if (y < 0) y += m;
        return y;
    endfunction

    function automatic t_rng_word predict_rng_word(logic cmd, logic [30:0] limit);
        longint            start;
        longint            idx;
        longint unsigned   capped;
        t_rng_word         w;
        if (cmd == CMD_RESEED) begin
            start = longint'(seed_reg) + 1;
            if (start > VAL_MAX || start < 1) start = 1;
            gen1_state = start;
            gen2_state = start;
            // warm up; the last TBL_DEPTH steps fill the table top down
            for (int j = TBL_DEPTH + 7; j >= 0; j--) begin
                gen1_state = schrage_step(gen1_state, GEN1_A, GEN1_M, GEN1_Q, GEN1_R);
                if (j < TBL_DEPTH) shuffle_tbl[j] = gen1_state;
            end
            shuffle_reg = shuffle_tbl[0];
            w.raw    = shuffle_reg[30:0];
            w.scaled = '0;
            return w;
        end
        gen1_state = schrage_step(gen1_state, GEN1_A, GEN1_M, GEN1_Q, GEN1_R);
        gen2_state = schrage_step(gen2_state, GEN2_A, GEN2_M, GEN2_Q, GEN2_R);
        idx = shuffle_reg / BUCKET;
        if (idx < 0) idx = 0;
        if (idx > TBL_DEPTH - 1) idx = TBL_DEPTH - 1;
        shuffle_reg = shuffle_tbl[int'(idx)] - gen2_state;
        shuffle_tbl[int'(idx)] = gen1_state;
        if (shuffle_reg < 0) shuffle_reg += WRAP_ADD;
        w.raw  = shuffle_reg[30:0];
        capped = (w.raw < SCALE_CAP) ? longint'(w.raw) : longint'(SCALE_CAP);
        capped = (capped * longint'(limit)) / longint'(GEN1_M);
        w.scaled = capped[30:0];
        return w;
    endfunction

    function automatic logic [30:0] pick_limit();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 31'd1;
            2:       return '1;
            3:       return 31'($urandom_range(1, 1000));
            default: return 31'($urandom());
        endcase
    endfunction

    function automatic logic [30:0] pick_seed();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return SEED_ZERO_GEN1;
            3:       return SEED_ZERO_GEN2;
            default: return 31'($urandom());
        endcase
    endfunction

    // Call at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(logic cmd, logic [30:0] limit);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {1'b0, limit};
        do @(posedge i_clk); while (!s_axis_tready);
        rng_words_due.push_back(predict_rng_word(cmd, limit));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (rng_words_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_seed(logic [30:0] seed);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_SEED, 2'b00};
        pwdata  = {1'b0, seed};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        seed_reg = seed;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Seed extremes, including the all-ones wrap and seeds that zero one generator,
    // each followed by draws at the range extremes.
    task automatic test_seed_edges();
        logic [30:0] seeds [5];
        seeds = '{'0, '1, 31'h7FFF_FFFE, SEED_ZERO_GEN1, SEED_ZERO_GEN2};
        foreach (seeds[i]) begin
            wait_idle();
            write_seed(seeds[i]);
            send_word(CMD_RESEED, '1);
            send_word(CMD_DRAW, '0);
            send_word(CMD_DRAW, '1);
            send_word(CMD_DRAW, 31'd1);
        end
        // back-to-back reseeds restart the same sequence
        send_word(CMD_RESEED, '0);
        send_word(CMD_RESEED, 31'($urandom()));
        send_word(CMD_DRAW, 31'd2);
    endtask

    // Mostly draw runs after a fresh seed, with the odd reseed in between.
    task automatic test_random_stream(int snd_pct, int rcv_pct);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        repeat (4) begin
            wait_idle();
            write_seed(pick_seed());
            send_word(CMD_RESEED, pick_limit());
            repeat (77) begin
                send_word(($urandom_range(99) < 4) ? CMD_RESEED : CMD_DRAW, pick_limit());
            end
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_rng_word exp_w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rng_words_due.size() == 0) begin
                $error("unexpected result word: raw_value %0d scaled_value %0d",
                       m_axis_tdata[30:0], m_axis_tdata[61:31]);
                mismatch_count++;
            end else begin
                exp_w = rng_words_due.pop_front();
                if (m_axis_tdata[30:0] !== exp_w.raw) begin
                    $error("raw_value: expected %0d, got %0d", exp_w.raw, m_axis_tdata[30:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[61:31] !== exp_w.scaled) begin
                    $error("scaled_value: expected %0d, got %0d",
                           exp_w.scaled, m_axis_tdata[61:31]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        m_axis_tready  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatch_count = 0;
        send_idle_pct  = 7;
        recv_idle_pct  = 46;
        seed_reg       = '0;
        gen1_state     = 0;
        gen2_state     = 0;
        shuffle_reg    = 0;
        foreach (shuffle_tbl[i]) shuffle_tbl[i] = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_seed_edges();
        test_random_stream(7, 46);
        test_random_stream(46, 7);
        test_random_stream(0, 0);

        wait_idle();
        repeat (100) @(negedge i_clk);
        if (mismatch_count == 0 && rng_words_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
